FILE: hdl/rde_pkg.sv
`timescale 1ns / 1ps
package rde_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    typedef logic [2:0]        t_op;
    typedef logic [1:0]        t_status;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_op OP_CLEAR   = 3'd0;
    localparam t_op OP_LOAD    = 3'd1;
    localparam t_op OP_REVERSE = 3'd2;
    localparam t_op OP_DELETE  = 3'd3;
    localparam t_op OP_EMIT    = 3'd4;

    localparam t_status ST_GIVEN = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_ERROR = 2'd2;

endpackage

FILE: hdl/rde_in_if.sv
`timescale 1ns / 1ps
interface rde_in_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        operation;
    logic signed [rde_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

FILE: hdl/rde_out_if.sv
`timescale 1ns / 1ps
interface rde_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rde_pkg::DATA_W-1:0] element;
    logic [1:0]                        status;
    logic                              last;

    modport source (output valid, output element, output status, output last, input ready);
    modport sink   (input valid, input element, input status, input last, output ready);
endinterface

FILE: hdl/rde_ram.sv
`timescale 1ns / 1ps
module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/reversible_deque_engine.sv
`timescale 1ns / 1ps
// Channel  | Dir | Payload                       | Transfer
// ---------+-----+-------------------------------+--------------------
// i_in     | in  | operation[2:0], value[31:0]   | valid & ready
// o_out    | out | element[31:0], status, last   | valid & ready (emit)
//
// Clear, load, reverse, delete and unknown codes retire at their transfer edge,
// so they may follow back to back. Emit reads the store at its transfer edge and
// loads the output register in the S_PUT state, so ready is low in that state,
// which lasts while the output register still holds an unaccepted result.
// Reset (synchronous, active low) empties the list and drops the error; the
// store is not cleared, since only entries written since the last clear are read.
module reversible_deque_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rde_in_if.sink    i_in,
    rde_out_if.source o_out
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_PUT  = 1'b1;

    logic                        r_state, n_state;
    rde_pkg::t_idx               r_front, n_front;
    rde_pkg::t_idx               r_back, n_back;
    logic                        r_rev, n_rev;
    logic                        r_err, n_err;
    rde_pkg::t_status            r_pend_status, n_pend_status;
    logic                        r_pend_last, n_pend_last;
    logic                        r_out_valid, n_out_valid;
    logic [rde_pkg::DATA_W-1:0]  r_out_element, n_out_element;
    rde_pkg::t_status            r_out_status, n_out_status;
    logic                        r_out_last, n_out_last;

    logic                        in_fire;
    logic                        is_empty;
    logic                        is_one;
    logic                        is_full;
    logic                        ram_we;
    logic                        ram_re;
    rde_pkg::t_addr              ram_raddr;
    logic [rde_pkg::DATA_W-1:0]  ram_rdata;
    rde_pkg::t_idx               back_dec;

    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign is_empty   = (r_back == r_front);
    assign is_one     = ((r_back - r_front) == rde_pkg::t_idx'(1));
    assign is_full    = (r_back == rde_pkg::t_idx'(rde_pkg::DEPTH));
    assign back_dec   = r_back - rde_pkg::t_idx'(1);
    // Logical front: physical back entry when reversed.
    assign ram_raddr  = r_rev ? back_dec[rde_pkg::ADDR_W-1:0]
                              : r_front[rde_pkg::ADDR_W-1:0];
    assign ram_we     = in_fire && (i_in.operation == rde_pkg::OP_LOAD) && !r_err && !is_full;
    assign ram_re     = in_fire && (i_in.operation == rde_pkg::OP_EMIT) && !r_err && !is_empty;

    rde_ram #(
        .WIDTH (rde_pkg::DATA_W),
        .DEPTH (rde_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_back[rde_pkg::ADDR_W-1:0]),
        .i_wdata (i_in.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_back        = r_back;
        n_rev         = r_rev;
        n_err         = r_err;
        n_pend_status = r_pend_status;
        n_pend_last   = r_pend_last;
        n_out_valid   = r_out_valid;
        n_out_element = r_out_element;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;

        // Drop the held result once the sink takes it.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.operation) inside
                        rde_pkg::OP_CLEAR: begin
                            n_front = '0;
                            n_back  = '0;
                            n_rev   = 1'b0;
                            n_err   = 1'b0;
                        end
                        rde_pkg::OP_LOAD: begin
                            if (!r_err) begin
                                if (is_full) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_back = r_back + rde_pkg::t_idx'(1);
                                end
                            end
                        end
                        rde_pkg::OP_REVERSE: begin
                            if (!r_err) begin
                                n_rev = !r_rev;
                            end
                        end
                        rde_pkg::OP_DELETE, rde_pkg::OP_EMIT: begin
                            if (r_err) begin
                                n_pend_status = rde_pkg::ST_ERROR;
                            end else if (is_empty) begin
                                n_pend_status = rde_pkg::ST_EMPTY;
                                if (i_in.operation == rde_pkg::OP_DELETE) begin
                                    n_err = 1'b1;
                                end
                            end else begin
                                n_pend_status = rde_pkg::ST_GIVEN;
                                // Advance the pointer now; for emit the read is already issued.
                                if (r_rev) begin
                                    n_back = back_dec;
                                end else begin
                                    n_front = r_front + rde_pkg::t_idx'(1);
                                end
                            end
                            n_pend_last = !r_err && is_one;
                            if (i_in.operation == rde_pkg::OP_EMIT) begin
                                n_state = S_PUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_pend_status;
                    n_out_last    = r_pend_last;
                    n_out_element = (r_pend_status == rde_pkg::ST_GIVEN) ? ram_rdata : '0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_rev       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_rev       <= n_rev;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_pend_status <= n_pend_status;
        r_pend_last   <= n_pend_last;
        r_out_element <= n_out_element;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.element = r_out_element;
    assign o_out.status  = r_out_status;
    assign o_out.last    = r_out_last;

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= r_back)
        else $error("front index passed back index");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_back <= rde_pkg::t_idx'(rde_pkg::DEPTH))
        else $error("back index beyond store depth");

    a_emit_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in.operation == rde_pkg::OP_EMIT) |=> r_state == S_PUT)
        else $error("emit transfer did not enter result stage");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_PUT)
        else $error("result appeared without a pending emit");

    a_last_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_status == rde_pkg::ST_GIVEN)
        else $error("last mark on a result without element");
endmodule
